// ----- design/assert_macros.svh -----
// Assertion macros shared by the point transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_HOLDS(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/hpt_pkg.sv -----
// Types, widths and codes for the homography point transform.
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int COEF_W        = 64;
  localparam int NCOEF         = 9;
  localparam int IDX_W         = 4;
  localparam int COORD_W       = 16;
  localparam int HALF_W        = COEF_W / 2;
  localparam int OPA_W         = HALF_W + 1;
  localparam int OPB_W         = COORD_W + 1;
  localparam int PROD_W        = OPA_W + OPB_W;
  localparam int SUM_W         = COEF_W + COORD_W + 2;
  localparam int MAG_W         = SUM_W - 1;
  localparam int OUT_W         = 57;
  localparam int OUT_FRAC_BITS = 40;
  localparam int HEAD_BITS     = OUT_W - OUT_FRAC_BITS;
  localparam int CNT_W         = $clog2(OUT_W);
  localparam int STATUS_W      = 2;

  typedef logic        [IDX_W-1:0]   idx_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OPA_W-1:0]   opa_t;
  typedef logic signed [OPB_W-1:0]   opb_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [OUT_W-1:0]   quo_t;
  typedef logic signed [OUT_W-1:0]   out_t;
  typedef logic        [CNT_W-1:0]   cnt_t;

  localparam idx_t LAST_IDX = idx_t'(NCOEF - 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LOADED = 2'd1,
    ST_W_ZERO     = 2'd2,
    ST_SAT        = 2'd3
  } status_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_XFORM = 1'b1
  } mode_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
    logic hi;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// ----- design/hpt_in_if.sv -----
// Input channel: coefficient loads and points to transform.
`timescale 1ns / 1ps
interface hpt_in_if;
  logic                    valid;
  logic                    ready;
  hpt_pkg::mode_t          mode;
  hpt_pkg::idx_t           coef_index;
  hpt_pkg::coef_t          coef_value;
  hpt_pkg::coord_t         x_coord;
  hpt_pkg::coord_t         y_coord;

  modport source (output valid, mode, coef_index, coef_value, x_coord, y_coord,
                  input ready);
  modport sink (input valid, mode, coef_index, coef_value, x_coord, y_coord,
                output ready);
endinterface

// ----- design/hpt_out_if.sv -----
// Result channel: mapped position and status.
`timescale 1ns / 1ps
interface hpt_out_if;
  logic                    valid;
  logic                    ready;
  hpt_pkg::out_t           lon_out;
  hpt_pkg::out_t           lat_out;
  hpt_pkg::status_t        status;

  modport source (output valid, lon_out, lat_out, status, input ready);
  modport sink (input valid, lon_out, lat_out, status, output ready);
endinterface

// ----- design/homography_point_transform_core.sv -----
// Top level: coefficient store, sequencer, shared multiplier and divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Homography point transform.
// in_ch carries two kinds of beat: a load (mode 0) writes one Q32.32
// coefficient, row-major index 0..8, and marks the matrix loaded; indexes
// 9..15 are dropped. A transform (mode 1) maps integer (x, y) through the
// 3x3 matrix and returns u/w and v/w in Q16.40 on out_ch, with a status.
// A load gives no result and leaves the block idle. A transform holds the
// block for its whole run: the three row sums pass through the shared
// 33x17 multiplier (18 passes), then the shared restoring divider runs
// twice, each run a start, an overflow test, 57 quotient bit steps and a
// hand-off, and out_ch.valid rises once the result is registered; a
// quotient that overflows skips its 57 bit steps. With no matrix loaded
// the multiplier and divider are skipped; with w zero, the divider is.
// in_ch.ready is high only between items; the next item is taken while a
// result still sits in the output register. If out_ch stalls, a finished
// result waits there and the block holds before the output stage.
// Reset clears the coefficients and the loaded flag and drops any result.
module homography_point_transform_core (
  input  logic      clk,
  input  logic      rst_n,
  hpt_in_if.sink    in_ch,
  hpt_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_MWAIT, S_DIV_U, S_WAIT_U, S_DIV_V, S_WAIT_V, S_FIN
  } state_t;

  state_t             state_r;
  hpt_pkg::coef_t     coef_r [hpt_pkg::NCOEF];
  logic               loaded_r;
  hpt_pkg::idx_t      idx_r;
  logic               half_r;
  hpt_pkg::coord_t    x_r;
  hpt_pkg::coord_t    y_r;
  hpt_pkg::sum_t      u_r;
  hpt_pkg::sum_t      v_r;
  hpt_pkg::sum_t      w_r;
  hpt_pkg::out_t      lon_r;
  hpt_pkg::out_t      lat_r;
  logic               sat_r;
  hpt_pkg::status_t   status_r;
  logic               out_valid_r;
  hpt_pkg::out_t      out_lon_r;
  hpt_pkg::out_t      out_lat_r;
  hpt_pkg::status_t   out_status_r;

  logic               in_fire;
  hpt_pkg::coef_t     coef_sel;
  hpt_pkg::mac_ctl_t  mac_ctl;
  hpt_pkg::opa_t      a_op;
  hpt_pkg::opb_t      b_op;
  hpt_pkg::sum_t      mac_acc;
  logic               mac_done;
  logic               div_start;
  hpt_pkg::mag_t      num_mag;
  hpt_pkg::mag_t      den_mag;
  hpt_pkg::div_stat_t div_stat;
  hpt_pkg::quo_t      div_quo;
  logic               neg_sel;
  logic [hpt_pkg::OUT_W:0] res_sat;

  function automatic hpt_pkg::mag_t mag_of(input hpt_pkg::sum_t v);
    logic [hpt_pkg::SUM_W-1:0] n;
    n = -v;
    return v[hpt_pkg::SUM_W-1] ? n[hpt_pkg::MAG_W-1:0] : v[hpt_pkg::MAG_W-1:0];
  endfunction

  // Apply sign and clamp; top bit of the result flags a clamp
  function automatic logic [hpt_pkg::OUT_W:0] sign_sat(input hpt_pkg::quo_t mag,
                                                       input logic ovf,
                                                       input logic neg);
    hpt_pkg::quo_t res;
    logic          sat;
    sat = 1'b0;
    if (neg) begin
      if (ovf || (mag[hpt_pkg::OUT_W-1] && |mag[hpt_pkg::OUT_W-2:0])) begin
        sat = 1'b1;
        res = {1'b1, {(hpt_pkg::OUT_W-1){1'b0}}};
      end else begin
        res = -mag;
      end
    end else begin
      if (ovf || mag[hpt_pkg::OUT_W-1]) begin
        sat = 1'b1;
        res = {1'b0, {(hpt_pkg::OUT_W-1){1'b1}}};
      end else begin
        res = mag;
      end
    end
    return {sat, res};
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Multiplier operands: coefficient half against x, y or one
  always_comb begin
    coef_sel      = coef_r[idx_r];
    mac_ctl.issue = (state_r == S_MUL);
    mac_ctl.first = !half_r && (idx_r inside {4'd0, 4'd3, 4'd6});
    mac_ctl.last  = half_r && (idx_r inside {4'd2, 4'd5, 4'd8});
    mac_ctl.hi    = half_r;
    a_op = half_r ? {coef_sel[hpt_pkg::COEF_W-1], coef_sel[hpt_pkg::COEF_W-1:hpt_pkg::HALF_W]}
                  : {1'b0, coef_sel[hpt_pkg::HALF_W-1:0]};
    if (idx_r inside {4'd0, 4'd3, 4'd6}) begin
      b_op = {x_r[hpt_pkg::COORD_W-1], x_r};
    end else if (idx_r inside {4'd1, 4'd4, 4'd7}) begin
      b_op = {y_r[hpt_pkg::COORD_W-1], y_r};
    end else begin
      b_op = {{(hpt_pkg::OPB_W-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    div_start = (state_r == S_DIV_U) || (state_r == S_DIV_V);
    num_mag   = (state_r == S_DIV_V) ? mag_of(v_r) : mag_of(u_r);
    den_mag   = mag_of(w_r);
    neg_sel   = ((state_r == S_WAIT_V) ? v_r[hpt_pkg::SUM_W-1] : u_r[hpt_pkg::SUM_W-1])
                ^ w_r[hpt_pkg::SUM_W-1];
    res_sat   = sign_sat(div_quo, div_stat.ovf, neg_sel);
  end

  hpt_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .a_op (a_op),
    .b_op (b_op),
    .acc  (mac_acc),
    .done (mac_done)
  );

  hpt_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_mag(num_mag),
    .den_mag(den_mag),
    .stat   (div_stat),
    .quo    (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < hpt_pkg::NCOEF; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      // Drop a taken beat; S_FIN refills the register itself
      if (out_valid_r && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.mode == hpt_pkg::MODE_LOAD) begin
              if (in_ch.coef_index <= hpt_pkg::LAST_IDX) begin
                coef_r[in_ch.coef_index] <= in_ch.coef_value;
                loaded_r                 <= 1'b1;
              end
            end else begin
              x_r    <= in_ch.x_coord;
              y_r    <= in_ch.y_coord;
              idx_r  <= '0;
              half_r <= 1'b0;
              sat_r  <= 1'b0;
              if (!loaded_r) begin
                lon_r    <= '0;
                lat_r    <= '0;
                status_r <= hpt_pkg::ST_NOT_LOADED;
                state_r  <= S_FIN;
              end else begin
                state_r <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          if (mac_ctl.last) begin
            state_r <= S_MWAIT;
          end else begin
            half_r <= ~half_r;
            if (half_r) begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_MWAIT: begin
          if (mac_done) begin
            case (idx_r)
              4'd2:    u_r <= mac_acc;
              4'd5:    v_r <= mac_acc;
              default: w_r <= mac_acc;
            endcase
            if (idx_r == hpt_pkg::LAST_IDX) begin
              if (mac_acc == '0) begin
                lon_r    <= '0;
                lat_r    <= '0;
                status_r <= hpt_pkg::ST_W_ZERO;
                state_r  <= S_FIN;
              end else begin
                state_r <= S_DIV_U;
              end
            end else begin
              idx_r   <= idx_r + 1'b1;
              half_r  <= 1'b0;
              state_r <= S_MUL;
            end
          end
        end
        S_DIV_U: state_r <= S_WAIT_U;
        S_WAIT_U: begin
          if (div_stat.done) begin
            lon_r   <= res_sat[hpt_pkg::OUT_W-1:0];
            sat_r   <= res_sat[hpt_pkg::OUT_W];
            state_r <= S_DIV_V;
          end
        end
        S_DIV_V: state_r <= S_WAIT_V;
        S_WAIT_V: begin
          if (div_stat.done) begin
            lat_r    <= res_sat[hpt_pkg::OUT_W-1:0];
            status_r <= (sat_r || res_sat[hpt_pkg::OUT_W]) ? hpt_pkg::ST_SAT : hpt_pkg::ST_OK;
            state_r  <= S_FIN;
          end
        end
        S_FIN: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_lon_r    <= lon_r;
            out_lat_r    <= lat_r;
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.lon_out = out_lon_r;
  assign out_ch.lat_out = out_lat_r;
  assign out_ch.status  = out_status_r;

  `ASSERT_HOLDS(a_fault_zero, out_ch.valid && (out_ch.status == hpt_pkg::ST_NOT_LOADED || out_ch.status == hpt_pkg::ST_W_ZERO), out_ch.lon_out == '0 && out_ch.lat_out == '0, "fault result with nonzero position")
  `ASSERT_NEXT(a_unloaded_fast, in_fire && in_ch.mode == hpt_pkg::MODE_XFORM && !loaded_r, state_r == S_FIN, "unloaded transform did not finish at once")
  `ASSERT_NEXT(a_load_stays_idle, in_fire && in_ch.mode == hpt_pkg::MODE_LOAD, state_r == S_IDLE, "load beat left idle")
  `ASSERT_HOLDS(a_div_free, div_start, !div_stat.busy, "divider started while busy")

endmodule

// ----- design/hpt_mac.sv -----
// Shared 33x17 signed multiplier with a registered product and a row accumulator.
`timescale 1ns / 1ps
module hpt_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  hpt_pkg::mac_ctl_t ctl,
  input  hpt_pkg::opa_t     a_op,
  input  hpt_pkg::opb_t     b_op,
  output hpt_pkg::sum_t     acc,
  output logic              done
);

  hpt_pkg::prod_t p_r;
  logic           v_r;
  logic           first_r;
  logic           last_r;
  logic           hi_r;
  logic           done_r;
  hpt_pkg::sum_t  acc_r;
  hpt_pkg::sum_t  ext;
  hpt_pkg::sum_t  term;

  // Upper coefficient half carries weight 2^32
  always_comb begin
    ext  = hpt_pkg::sum_t'(p_r);
    term = hi_r ? (ext <<< hpt_pkg::HALF_W) : ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v_r    <= ctl.issue;
      done_r <= v_r && last_r;
    end
    p_r     <= a_op * b_op;
    first_r <= ctl.first;
    last_r  <= ctl.last;
    hi_r    <= ctl.hi;
    if (v_r) begin
      acc_r <= first_r ? term : acc_r + term;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

// ----- design/hpt_div.sv -----
// Restoring divider, one quotient bit per cycle, with an up-front overflow test.
`timescale 1ns / 1ps
module hpt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  hpt_pkg::mag_t      num_mag,
  input  hpt_pkg::mag_t      den_mag,
  output hpt_pkg::div_stat_t stat,
  output hpt_pkg::quo_t      quo
);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_ITER} dstate_t;

  dstate_t                       st_r;
  logic                          done_r;
  logic                          ovf_r;
  hpt_pkg::mag_t                 num_r;
  hpt_pkg::mag_t                 den_r;
  hpt_pkg::mag_t                 rem_r;
  logic [hpt_pkg::HEAD_BITS-1:0] feed_r;
  hpt_pkg::quo_t                 quo_r;
  hpt_pkg::cnt_t                 cnt_r;

  logic [hpt_pkg::MAG_W:0]       trial;
  logic [hpt_pkg::MAG_W+1:0]     diff;
  logic                          ge;
  logic                          too_big;

  always_comb begin
    trial   = {rem_r, feed_r[hpt_pkg::HEAD_BITS-1]};
    diff    = {1'b0, trial} - {2'b00, den_r};
    ge      = ~diff[hpt_pkg::MAG_W+1];
    // Quotient reaches 2^57 exactly when num >= den * 2^17
    too_big = {{hpt_pkg::HEAD_BITS{1'b0}}, num_r} >= {den_r, {hpt_pkg::HEAD_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            num_r <= num_mag;
            den_r <= den_mag;
            st_r  <= D_CHECK;
          end
        end
        D_CHECK: begin
          quo_r <= '0;
          if (too_big) begin
            ovf_r  <= 1'b1;
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end else begin
            ovf_r  <= 1'b0;
            rem_r  <= hpt_pkg::mag_t'(num_r[hpt_pkg::MAG_W-1:hpt_pkg::HEAD_BITS]);
            feed_r <= num_r[hpt_pkg::HEAD_BITS-1:0];
            cnt_r  <= hpt_pkg::cnt_t'(hpt_pkg::OUT_W - 1);
            st_r   <= D_ITER;
          end
        end
        D_ITER: begin
          rem_r  <= ge ? diff[hpt_pkg::MAG_W-1:0] : trial[hpt_pkg::MAG_W-1:0];
          quo_r  <= {quo_r[hpt_pkg::OUT_W-2:0], ge};
          feed_r <= {feed_r[hpt_pkg::HEAD_BITS-2:0], 1'b0};
          if (cnt_r == '0) begin
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = (st_r != D_IDLE);
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quo       = quo_r;

endmodule
